// ===== design/afsa_pkg.sv =====
package afsa_pkg;

  localparam int unsigned DimW = 11;
  localparam int unsigned QuotW = 10;
  localparam int unsigned RemW = 20;
  localparam int unsigned DefScreenWidth = 240;
  localparam int unsigned DefScreenHeight = 160;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_IMAGE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    REG_SRC_W   = 3'd0,
    REG_SRC_H   = 3'd1,
    REG_PITCH   = 3'd2,
    REG_BOX_L   = 3'd3,
    REG_BOX_T   = 3'd4,
    REG_BOX_W   = 3'd5,
    REG_BOX_H   = 3'd6,
    REG_BG      = 3'd7
  } reg_e;

  typedef struct packed {
    logic              en;
    logic              busy;
    logic [9:0]        src_w;
    logic [9:0]        src_h;
    logic [9:0]        pitch;
    logic signed [11:0] box_l;
    logic signed [11:0] box_t;
    logic signed [11:0] box_r;
    logic signed [11:0] box_b;
    logic signed [11:0] img_l;
    logic signed [11:0] img_t;
    logic signed [11:0] img_r;
    logic signed [11:0] img_b;
    logic [DimW-1:0]   out_w;
    logic [DimW-1:0]   out_h;
    logic [15:0]       bg;
  } fit_t;

  typedef struct packed {
    logic             valid;
    kind_e            kind;
    logic [RemW-1:0]  rem_c;
    logic [RemW-1:0]  rem_r;
    logic [QuotW-1:0] q_c;
    logic [QuotW-1:0] q_r;
  } cell_t;

endpackage

// ===== design/afsa_fit.sv =====
module afsa_fit
  import afsa_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH = DefScreenWidth,
  parameter int unsigned SCREEN_HEIGHT = DefScreenHeight
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output fit_t        fit_o
);

  typedef enum logic [2:0] {F_IDLE, F_MUL, F_SEL, F_DIV, F_FIN} state_e;

  state_e state_q;
  logic [9:0]  sw_q, sh_q, pitch_q;
  logic signed [9:0] bl_q, bt_q;
  logic [8:0]  bw_q, bh_q;
  logic [15:0] bg_q;
  logic [18:0] p1_q, p2_q, num_q;
  logic [10:0] rem_q;
  logic [9:0]  den_q;
  logic        wl_q;
  logic [4:0]  cnt_q;
  logic        en_q;
  logic [DimW-1:0] ow_q, oh_q;
  logic signed [11:0] ix_q, iy_q;

  logic [10:0] rem_sh;
  logic        take;
  logic [DimW-1:0] pw, ph, qc, qw, qh, lim_w, lim_h;
  logic        zero;

  assign lim_w = DimW'(SCREEN_WIDTH);
  assign lim_h = DimW'(SCREEN_HEIGHT);
  assign rem_sh = {rem_q[9:0], num_q[18]};
  assign take = rem_sh >= {1'b0, den_q};
  assign zero = (sw_q == '0) || (sh_q == '0) || (bw_q == '0) || (bh_q == '0);

  always_comb begin
    pw = ({2'b0, bw_q} > lim_w) ? lim_w : {2'b0, bw_q};
    ph = ({2'b0, bh_q} > lim_h) ? lim_h : {2'b0, bh_q};
    qc = (num_q > 19'(1023)) ? DimW'(1024) : DimW'(num_q);
    if (qc == '0) qc = DimW'(1);
    qw = (qc > lim_w) ? lim_w : qc;
    qh = (qc > lim_h) ? lim_h : qc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      en_q <= 1'b0;
      sw_q <= '0;
      sh_q <= '0;
      pitch_q <= '0;
      bl_q <= '0;
      bt_q <= '0;
      bw_q <= '0;
      bh_q <= '0;
      bg_q <= '0;
    end else if (cfg_we_i) begin
      state_q <= F_MUL;
      en_q <= 1'b0;
      case (reg_e'(cfg_index_i))
        REG_SRC_W: sw_q <= cfg_data_i[9:0];
        REG_SRC_H: sh_q <= cfg_data_i[9:0];
        REG_PITCH: pitch_q <= cfg_data_i[9:0];
        REG_BOX_L: bl_q <= cfg_data_i[9:0];
        REG_BOX_T: bt_q <= cfg_data_i[9:0];
        REG_BOX_W: bw_q <= cfg_data_i[8:0];
        REG_BOX_H: bh_q <= cfg_data_i[8:0];
        REG_BG:    bg_q <= cfg_data_i;
        default:   bg_q <= bg_q;
      endcase
    end else begin
      case (state_q)
        F_MUL: begin
          state_q <= F_SEL;
        end
        F_SEL: begin
          state_q <= F_DIV;
        end
        F_DIV: begin
          if (cnt_q == 5'd18) state_q <= F_FIN;
        end
        F_FIN: begin
          state_q <= F_IDLE;
          en_q <= !zero;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      F_MUL: begin
        p1_q <= 19'(bw_q * sh_q);
        p2_q <= 19'(bh_q * sw_q);
      end
      F_SEL: begin
        wl_q <= p1_q <= p2_q;
        num_q <= (p1_q <= p2_q) ? p1_q : p2_q;
        den_q <= (p1_q <= p2_q) ? sw_q : sh_q;
        rem_q <= '0;
        cnt_q <= '0;
      end
      F_DIV: begin
        cnt_q <= cnt_q + 5'd1;
        rem_q <= take ? (rem_sh - {1'b0, den_q}) : rem_sh;
        num_q <= {num_q[17:0], take};
      end
      F_FIN: begin
        ow_q <= wl_q ? pw : qw;
        oh_q <= wl_q ? qh : ph;
        ix_q <= 12'(bl_q) + 12'(({2'b0, bw_q} - (wl_q ? pw : qw)) >> 1);
        iy_q <= 12'(bt_q) + 12'(({2'b0, bh_q} - (wl_q ? qh : ph)) >> 1);
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
  end

  always_comb begin
    fit_o.en = en_q;
    fit_o.busy = (state_q != F_IDLE);
    fit_o.src_w = sw_q;
    fit_o.src_h = sh_q;
    fit_o.pitch = pitch_q;
    fit_o.box_l = 12'(bl_q);
    fit_o.box_t = 12'(bt_q);
    fit_o.box_r = 12'(bl_q) + 12'(bw_q);
    fit_o.box_b = 12'(bt_q) + 12'(bh_q);
    fit_o.img_l = ix_q;
    fit_o.img_t = iy_q;
    fit_o.img_r = ix_q + 12'(ow_q);
    fit_o.img_b = iy_q + 12'(oh_q);
    fit_o.out_w = ow_q;
    fit_o.out_h = oh_q;
    fit_o.bg = bg_q;
  end

endmodule

// ===== design/afsa_div_cell.sv =====
module afsa_div_cell
  import afsa_pkg::*;
#(
  parameter int unsigned SHIFT = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic [DimW-1:0] div_c_i,
  input  logic [DimW-1:0] div_r_i,
  input  cell_t           cell_i,
  output cell_t           cell_o
);

  cell_t cell_q;
  logic [RemW:0] trial_c, trial_r;
  logic take_c, take_r;

  assign trial_c = (RemW+1)'(div_c_i) << SHIFT;
  assign trial_r = (RemW+1)'(div_r_i) << SHIFT;
  assign take_c = {1'b0, cell_i.rem_c} >= trial_c;
  assign take_r = {1'b0, cell_i.rem_r} >= trial_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (adv_i) begin
      cell_q.valid <= cell_i.valid;
      cell_q.kind <= cell_i.kind;
      cell_q.rem_c <= take_c ? cell_i.rem_c - trial_c[RemW-1:0] : cell_i.rem_c;
      cell_q.rem_r <= take_r ? cell_i.rem_r - trial_r[RemW-1:0] : cell_i.rem_r;
      cell_q.q_c <= cell_i.q_c | (QuotW'(take_c) << SHIFT);
      cell_q.q_r <= cell_i.q_r | (QuotW'(take_r) << SHIFT);
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== design/aspect_fit_scaler_address.sv =====
// Aspect-fit nearest-neighbor scaler, address stage.
// The slave stream takes one screen coordinate per word, x in tdata[7:0]
// and y in tdata[15:8]. For each word the master stream returns one word:
// tuser holds the kind (none, margin or image pixel), tdata the source
// column, row, source offset and the margin color.
// Registers are written through the cfg channel, which is always ready.
// After each write a small sequencer recomputes the fitted size with a
// serial divider; s_axis_tready stays low in the write cycle and while
// the sequencer is busy.
// Words then flow at one per cycle unless the output stalls. An accepted
// input word passes a compare stage, a multiply stage, a row of ten
// divider cells (one quotient bit of column and row each) and the output
// register, which also forms the source offset (row times pitch plus column).
// The whole pipeline holds while the output word waits and m_axis_tready
// is low; s_axis_tready then falls in the same cycle, so no word is lost.
// Reset clears all registers to zero, which disables drawing, and empties
// the pipeline.
module aspect_fit_scaler_address
  import afsa_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH = DefScreenWidth,
  parameter int unsigned SCREEN_HEIGHT = DefScreenHeight
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // screen_x, screen_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // source_col, source_row, source_offset, fill_color
  output logic [1:0]  m_axis_tuser    // pixel_kind
);

  fit_t fit;
  logic adv;
  logic f_valid_q, out_valid_q;
  kind_e f_kind_q, f_kind_d, out_kind_q;
  logic [DimW-1:0] f_dx_q, f_dy_q;
  logic signed [11:0] sx, sy;
  logic in_box, in_img;
  cell_t chain [0:QuotW];
  logic [9:0] out_col_q, out_row_q;
  logic [19:0] out_off_q;
  logic [15:0] out_fill_q;

  afsa_fit #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_fit (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_valid_i),
    .cfg_index_i,
    .cfg_data_i,
    .fit_o(fit)
  );

  assign cfg_ready_o = 1'b1;
  assign adv = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv && !fit.busy && !cfg_valid_i;

  assign sx = 12'(s_axis_tdata[7:0]);
  assign sy = 12'(s_axis_tdata[15:8]);

  always_comb begin
    in_box = fit.en
      && ({3'b0, s_axis_tdata[7:0]} < DimW'(SCREEN_WIDTH))
      && ({3'b0, s_axis_tdata[15:8]} < DimW'(SCREEN_HEIGHT))
      && (sx >= fit.box_l) && (sx < fit.box_r)
      && (sy >= fit.box_t) && (sy < fit.box_b);
    in_img = (sx >= fit.img_l) && (sx < fit.img_r)
      && (sy >= fit.img_t) && (sy < fit.img_b);
    f_kind_d = !in_box ? KIND_NONE : (in_img ? KIND_IMAGE : KIND_FILL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
      f_kind_q <= KIND_NONE;
      f_dx_q <= '0;
      f_dy_q <= '0;
      chain[0] <= '0;
      out_valid_q <= 1'b0;
      out_kind_q <= KIND_NONE;
      out_col_q <= '0;
      out_row_q <= '0;
      out_off_q <= '0;
      out_fill_q <= '0;
    end else if (adv) begin
      f_valid_q <= s_axis_tvalid && s_axis_tready;
      f_kind_q <= f_kind_d;
      f_dx_q <= DimW'(sx - fit.img_l);
      f_dy_q <= DimW'(sy - fit.img_t);
      chain[0].valid <= f_valid_q;
      chain[0].kind <= f_kind_q;
      chain[0].rem_c <= RemW'(f_dx_q * fit.src_w);
      chain[0].rem_r <= RemW'(f_dy_q * fit.src_h);
      chain[0].q_c <= '0;
      chain[0].q_r <= '0;
      out_valid_q <= chain[QuotW].valid;
      out_kind_q <= chain[QuotW].kind;
      out_col_q <= (chain[QuotW].kind == KIND_IMAGE) ? chain[QuotW].q_c : '0;
      out_row_q <= (chain[QuotW].kind == KIND_IMAGE) ? chain[QuotW].q_r : '0;
      out_off_q <= (chain[QuotW].kind == KIND_IMAGE)
        ? 20'(chain[QuotW].q_r * fit.pitch) + 20'(chain[QuotW].q_c) : '0;
      out_fill_q <= (chain[QuotW].kind == KIND_FILL) ? fit.bg : '0;
    end
  end

  for (genvar k = 0; k < QuotW; k++) begin : g_cell
    afsa_div_cell #(.SHIFT(QuotW - 1 - k)) u_cell (
      .clk_i, .rst_ni,
      .adv_i(adv),
      .div_c_i(fit.out_w),
      .div_r_i(fit.out_h),
      .cell_i(chain[k]),
      .cell_o(chain[k+1])
    );
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser = out_kind_q;
  assign m_axis_tdata = {out_fill_q, out_off_q, out_row_q, out_col_q};

endmodule

// ===== bench/afsa_checker.sv =====
`timescale 1ns / 1ps

module afsa_checker
  import afsa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    kind_e       kind;
    logic [9:0]  col;
    logic [9:0]  row;
    logic [19:0] offset;
    logic [15:0] fill;
  } pixel_t;

  logic [9:0]        src_w, src_h, pitch;
  logic signed [9:0] box_l, box_t;
  logic [8:0]        box_w, box_h;
  logic [15:0]       bg;

  pixel_t pixel_q[$];

  function automatic pixel_t fit_pixel(input logic [7:0] px, input logic [7:0] py);
    pixel_t r;
    int x, y, sw, sh, bw, bh, bx, by, ow, oh, ix, iy, c, rw;
    r = '{kind: KIND_NONE, default: '0};
    x = px;
    y = py;
    sw = src_w;
    sh = src_h;
    bw = box_w;
    bh = box_h;
    bx = box_l;
    by = box_t;
    if (sw < 1 || sh < 1 || bw < 1 || bh < 1) return r;
    if (x >= DefScreenWidth || y >= DefScreenHeight) return r;
    if (x < bx || x >= bx + bw || y < by || y >= by + bh) return r;
    if (bw * sh <= bh * sw) begin
      ow = bw;
      oh = sh * bw / sw;
    end else begin
      oh = bh;
      ow = sw * bh / sh;
    end
    if (ow < 1) ow = 1;
    if (oh < 1) oh = 1;
    if (ow > DefScreenWidth) ow = DefScreenWidth;
    if (oh > DefScreenHeight) oh = DefScreenHeight;
    ix = bx + (bw - ow) / 2;
    iy = by + (bh - oh) / 2;
    if (x >= ix && x < ix + ow && y >= iy && y < iy + oh) begin
      c = (x - ix) * sw / ow;
      rw = (y - iy) * sh / oh;
      r.kind = KIND_IMAGE;
      r.col = c[9:0];
      r.row = rw[9:0];
      r.offset = 20'(rw * int'(pitch) + c);
    end else begin
      r.kind = KIND_FILL;
      r.fill = bg;
    end
    return r;
  endfunction

  assign pending_o = pixel_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want, got;
    if (!rst_ni) begin
      src_w = '0; src_h = '0; pitch = '0; box_l = '0; box_t = '0;
      box_w = '0; box_h = '0; bg = '0;
      fail_count_o = 0;
      pixel_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = kind_e'(m_axis_tuser);
        got.col = m_axis_tdata[9:0];
        got.row = m_axis_tdata[19:10];
        got.offset = m_axis_tdata[39:20];
        got.fill = m_axis_tdata[55:40];
        if (pixel_q.size() == 0) begin
          $error("output word with no pending pixel");
          fail_count_o++;
        end else begin
          want = pixel_q.pop_front();
          if (got.kind != want.kind) begin
            $error("pixel_kind expected %0d got %0d", want.kind, got.kind);
            fail_count_o++;
          end
          if (got.col != want.col) begin
            $error("source_col expected %0d got %0d", want.col, got.col);
            fail_count_o++;
          end
          if (got.row != want.row) begin
            $error("source_row expected %0d got %0d", want.row, got.row);
            fail_count_o++;
          end
          if (got.offset != want.offset) begin
            $error("source_offset expected %0d got %0d", want.offset, got.offset);
            fail_count_o++;
          end
          if (got.fill != want.fill) begin
            $error("fill_color expected %0d got %0d", want.fill, got.fill);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        pixel_q.push_back(fit_pixel(s_axis_tdata[7:0], s_axis_tdata[15:8]));
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_e'(cfg_index_i))
          REG_SRC_W: src_w = cfg_data_i[9:0];
          REG_SRC_H: src_h = cfg_data_i[9:0];
          REG_PITCH: pitch = cfg_data_i[9:0];
          REG_BOX_L: box_l = cfg_data_i[9:0];
          REG_BOX_T: box_t = cfg_data_i[9:0];
          REG_BOX_W: box_w = cfg_data_i[8:0];
          REG_BOX_H: box_h = cfg_data_i[8:0];
          REG_BG:    bg = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import afsa_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // screen_x, screen_y
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // source_col, source_row, source_offset, fill_color
  logic [1:0]  m_axis_tuser;        // pixel_kind

  int fail_count, pending;
  int src_idle_pct = 27;
  int rx_idle_pct = 27;
  int hold_left = 0;
  bit hold_request = 1'b0;

  always #6 clk_i = ~clk_i;

  aspect_fit_scaler_address dut (.*);

  afsa_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // The receiver runs its own long hold-off when asked, so the pipeline backs up.
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_pixel(input logic [7:0] x, input logic [7:0] y);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_fit(input logic [9:0] sw, input logic [9:0] sh, input logic [9:0] pitch,
                         input logic [9:0] bl, input logic [9:0] bt, input logic [8:0] bw,
                         input logic [8:0] bh, input logic [15:0] color);
    logic [15:0] vals[8];
    vals = '{16'(sw), 16'(sh), 16'(pitch), 16'(bl), 16'(bt), 16'(bw), 16'(bh), color};
    for (int i = 0; i < 8; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= reg_e'(i);
      cfg_data_i <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_fit();
    int sw, sh, bl, bt, bw, bh;
    sw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 1023);
    sh = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 1023);
    if ($urandom_range(0, 9) == 0) sw = 0;
    bl = int'($urandom_range(0, 300)) - 60;
    bt = int'($urandom_range(0, 220)) - 60;
    bw = $urandom_range(1, 511);
    bh = $urandom_range(1, 511);
    if ($urandom_range(0, 9) == 0) bh = 0;
    if ($urandom_range(0, 9) == 0) bl = int'($urandom_range(0, 1023)) - 512;
    set_fit(10'(sw), 10'(sh), 10'($urandom_range(0, 1023)), 10'(bl), 10'(bt), 9'(bw),
            9'(bh), 16'($urandom_range(0, 65535)));
  endtask

  initial begin
    logic [7:0] x, y;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // All registers zero after reset: drawing is disabled.
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd100, 8'd50);
    drain();

    // Width-limited fit with a box partly off screen.
    set_fit(10'd100, 10'd50, 10'd100, -10'sd20, 10'sd10, 9'd200, 9'd120, 16'hA5A5);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd239, 8'd159);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd240, 8'd20);
    send_pixel(8'd20, 8'd160);
    send_pixel(8'd0, 8'd40);
    send_pixel(8'd179, 8'd129);
    send_pixel(8'd180, 8'd60);
    send_pixel(8'd50, 8'd20);
    send_pixel(8'd50, 8'd9);
    drain();

    // Square fit with the widest box and full pitch: the tie picks the width-limited fit.
    set_fit(10'd1023, 10'd1023, 10'd1023, -10'sd512, -10'sd512, 9'd511, 9'd511, 16'hFFFF);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd239, 8'd159);
    drain();

    // Extreme aspect: the fitted height clamps up to one row.
    set_fit(10'd1023, 10'd1, 10'd1023, 10'sd0, 10'sd0, 9'd511, 9'd511, 16'h5A5A);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd239, 8'd0);
    send_pixel(8'd10, 8'd100);
    send_pixel(8'd10, 8'd0);
    drain();

    // Box entirely off screen and one-pixel sizes.
    set_fit(10'd1, 10'd1, 10'd0, 10'sd511, 10'sd511, 9'd1, 9'd1, 16'h0001);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd239, 8'd159);
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      src_idle_pct = (phase == 5) ? 0 : 27;
      rx_idle_pct = (phase == 5) ? 0 : 27;
      random_fit();
      for (int n = 0; n < 85; n++) begin
        if (phase == 3 && n == 10) hold_request = 1'b1;
        x = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 239));
        y = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 159));
        send_pixel(x, y);
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/afsa_pkg.sv
design/afsa_fit.sv
design/afsa_div_cell.sv
design/aspect_fit_scaler_address.sv
bench/afsa_checker.sv
bench/tb.sv
